/* sv/ajb_pkg.sv */
// ----------------------------------------------------------------------------
// Audio jitter buffer package
// Item types, request and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ajb_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] session_number;
      logic [63:0] first_byte;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
      logic        byte_last;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       cell_last;
   } rsp_item_type;

   localparam int BB_W = 17;
   localparam logic [BB_W-1:0] BUFFER_BYTES_RESET = 17'd65536;

   localparam logic [1:0] REQ_HEADER  = 2'd0;
   localparam logic [1:0] REQ_PAYLOAD = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   localparam logic [2:0] ST_NEW_SESSION   = 3'd0;
   localparam logic [2:0] ST_HDR_ACCEPTED  = 3'd1;
   localparam logic [2:0] ST_HDR_DROPPED   = 3'd2;
   localparam logic [2:0] ST_BYTE_STORED   = 3'd3;
   localparam logic [2:0] ST_BYTE_IGNORED  = 3'd4;
   localparam logic [2:0] ST_BYTE_OUT      = 3'd5;
   localparam logic [2:0] ST_NOT_STARTED   = 3'd6;
   localparam logic [2:0] ST_WAITING       = 3'd7;

   localparam logic [4:0] OP_IDLE     = 5'd0;
   localparam logic [4:0] OP_LATCH    = 5'd1;
   localparam logic [4:0] OP_EVAL     = 5'd2;
   localparam logic [4:0] OP_HDR_NEW  = 5'd3;
   localparam logic [4:0] OP_HDR_SAME = 5'd4;
   localparam logic [4:0] OP_DIV_CC   = 5'd5;
   localparam logic [4:0] OP_SET_CC   = 5'd6;
   localparam logic [4:0] OP_SET_SPAN = 5'd7;
   localparam logic [4:0] OP_DIV_Q    = 5'd8;
   localparam logic [4:0] OP_DIV_R    = 5'd9;
   localparam logic [4:0] OP_MUL      = 5'd10;
   localparam logic [4:0] OP_SET_WB   = 5'd11;
   localparam logic [4:0] OP_SET_RB   = 5'd12;
   localparam logic [4:0] OP_CHK      = 5'd13;
   localparam logic [4:0] OP_PAY      = 5'd14;
   localparam logic [4:0] OP_LAG      = 5'd15;
   localparam logic [4:0] OP_RMEM     = 5'd16;
   localparam logic [4:0] OP_RDAT     = 5'd17;
   localparam logic [4:0] OP_CLR      = 5'd18;

   typedef struct packed {
      logic [4:0] op;
      logic       src_rp;
      logic       rsp_fire;
      logic [2:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       sess_lt;
      logic       sess_gt;
      logic       bad_len;
      logic       inval;
      logic       fb_le_start;
      logic       fb_in_lag;
      logic       stopped;
      logic       ro_zero;
      logic       rp_ahead;
      logic       pay_ok;
      logic       div_busy;
      logic       clr_last;
   } dp_stat_type;

endpackage

/* sv/audio_packet_jitter_buffer.sv */
// ----------------------------------------------------------------------------
// Audio packet jitter buffer
// Circular buffer for session-numbered audio packets with paced playback.
// ----------------------------------------------------------------------------
// Usage: pulse start with req_item while busy is low; the item is taken at
// that edge. req_type selects a packet header, one payload byte or one read.
// Exactly one result per item appears on rsp_item for one cycle with
// rsp_valid high; the receiver has no way to hold it off.
// Steps from the accepting edge to the result strobe:
//   payload byte or unknown request: handled without the divider
//   read inside a cell: store read, no divider pass
//   read at a cell start: lag check, two divider passes, then the store read
//   header of the current session: the same two divider passes
//   header of a new session: a divider pass for the cell count, the same
//     two passes, then clearing of the whole store, one byte per cycle
// Header and cell-start paths wait on the shared bit-serial divider; busy drops with each result.
// After reset all STORE_BYTES bytes of the store are cleared with busy high;
// register writes on psel/penable/pwrite are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_packet_jitter_buffer #(
   parameter int STORE_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ajb_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output ajb_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import ajb_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [16:0] buffer_bytes;

   ajb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .buffer_bytes (buffer_bytes)
   );

   ajb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   ajb_dp #(
      .STORE_BYTES (STORE_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .cmd          (cmd),
      .buffer_bytes (buffer_bytes),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

endmodule

/* sv/ajb_div.sv */
// ----------------------------------------------------------------------------
// Audio jitter buffer divider
// Restoring divider, 64-bit dividend by 17-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ajb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [16:0] divisor,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [16:0] remainder
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [17:0] shifted;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[63]};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? 17'(shifted - {1'b0, dvs_ff}) : shifted[16:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* sv/ajb_csr.sv */
// ----------------------------------------------------------------------------
// Audio jitter buffer register port
// APB-style access to the buffer size register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ajb_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [16:0] buffer_bytes
);
   import ajb_pkg::*;

   logic [BB_W-1:0] buffer_bytes_ff, buffer_bytes_in;
   logic            hit;

   assign hit = paddr[2] == 1'b0;

   always_comb begin
      buffer_bytes_in = buffer_bytes_ff;
      if (psel && penable && pwrite && hit) begin
         buffer_bytes_in = pwdata[BB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff <= BUFFER_BYTES_RESET;
      end else begin
         buffer_bytes_ff <= buffer_bytes_in;
      end
   end

   assign prdata       = hit ? {15'd0, buffer_bytes_ff} : 32'd0;
   assign pready       = 1'b1;
   assign buffer_bytes = buffer_bytes_ff;

endmodule

/* sv/ajb_ctrl.sv */
// ----------------------------------------------------------------------------
// Audio jitter buffer controller
// Sequences headers, payload bytes, reads and store clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ajb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  ajb_pkg::dp_stat_type stat,
   output logic                 busy,
   output ajb_pkg::dp_cmd_type  cmd
);
   import ajb_pkg::*;

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_BAD   = 5'd2;
   localparam logic [4:0] S_PAY   = 5'd3;
   localparam logic [4:0] S_EVAL  = 5'd4;
   localparam logic [4:0] S_HDR   = 5'd5;
   localparam logic [4:0] S_EVAL2 = 5'd6;
   localparam logic [4:0] S_DCC   = 5'd7;
   localparam logic [4:0] S_DCC_W = 5'd8;
   localparam logic [4:0] S_SPAN  = 5'd9;
   localparam logic [4:0] S_CBQ   = 5'd10;
   localparam logic [4:0] S_CBQ_W = 5'd11;
   localparam logic [4:0] S_CBR   = 5'd12;
   localparam logic [4:0] S_CBR_W = 5'd13;
   localparam logic [4:0] S_CBM   = 5'd14;
   localparam logic [4:0] S_CBSET = 5'd15;
   localparam logic [4:0] S_CHK   = 5'd16;
   localparam logic [4:0] S_RDEC  = 5'd17;
   localparam logic [4:0] S_RLAG  = 5'd18;
   localparam logic [4:0] S_RCHK  = 5'd19;
   localparam logic [4:0] S_RMEM  = 5'd20;
   localparam logic [4:0] S_RDAT  = 5'd21;

   logic [4:0] state_ff, state_in;
   logic       cb_read_ff, cb_read_in;
   logic       cb_new_ff, cb_new_in;
   logic       clr_fire_ff, clr_fire_in;

   always_comb begin
      state_in    = state_ff;
      cb_read_in  = cb_read_ff;
      cb_new_in   = cb_new_ff;
      clr_fire_in = clr_fire_ff;
      cmd         = '0;
      case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) begin
               state_in    = S_IDLE;
               clr_fire_in = 1'b0;
               if (clr_fire_ff) begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = ST_NEW_SESSION;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               case (req_kind)
                  REQ_HEADER, REQ_READ: state_in = S_EVAL;
                  REQ_PAYLOAD:          state_in = S_PAY;
                  default:              state_in = S_BAD;
               endcase
            end
         end
         S_BAD: begin
            cmd.rsp_fire   = 1'b1;
            cmd.rsp_status = ST_BYTE_IGNORED;
            state_in       = S_IDLE;
         end
         S_PAY: begin
            cmd.op         = OP_PAY;
            cmd.rsp_fire   = 1'b1;
            cmd.rsp_status = stat.pay_ok ? ST_BYTE_STORED : ST_BYTE_IGNORED;
            state_in       = S_IDLE;
         end
         S_EVAL: begin
            cmd.op   = OP_EVAL;
            state_in = (stat.req_kind == REQ_HEADER) ? S_HDR : S_RDEC;
         end
         S_HDR: begin
            if (stat.sess_lt) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_HDR_DROPPED;
               state_in       = S_IDLE;
            end else if (stat.sess_gt) begin
               cmd.op = OP_HDR_NEW;
               if (stat.bad_len) begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = ST_HDR_DROPPED;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_DCC;
               end
            end else begin
               cmd.op = OP_HDR_SAME;
               if (stat.inval || stat.fb_le_start) begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = ST_HDR_DROPPED;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_EVAL2;
               end
            end
         end
         S_EVAL2: begin
            if (stat.fb_in_lag) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_HDR_DROPPED;
               state_in       = S_IDLE;
            end else begin
               cb_read_in = 1'b0;
               cb_new_in  = 1'b0;
               state_in   = S_CBQ;
            end
         end
         S_DCC: begin
            cmd.op   = OP_DIV_CC;
            state_in = S_DCC_W;
         end
         S_DCC_W: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_SET_CC;
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            cmd.op     = OP_SET_SPAN;
            cb_read_in = 1'b0;
            cb_new_in  = 1'b1;
            state_in   = S_CBQ;
         end
         S_CBQ: begin
            cmd.op     = OP_DIV_Q;
            cmd.src_rp = cb_read_ff;
            state_in   = S_CBQ_W;
         end
         S_CBQ_W: begin
            if (!stat.div_busy) begin
               state_in = S_CBR;
            end
         end
         S_CBR: begin
            cmd.op   = OP_DIV_R;
            state_in = S_CBR_W;
         end
         S_CBR_W: begin
            if (!stat.div_busy) begin
               state_in = S_CBM;
            end
         end
         S_CBM: begin
            cmd.op   = OP_MUL;
            state_in = S_CBSET;
         end
         S_CBSET: begin
            if (cb_read_ff) begin
               cmd.op   = OP_SET_RB;
               state_in = S_RMEM;
            end else begin
               cmd.op   = OP_SET_WB;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cmd.op = OP_CHK;
            if (cb_new_ff) begin
               clr_fire_in = 1'b1;
               state_in    = S_CLR;
            end else begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_HDR_ACCEPTED;
               state_in       = S_IDLE;
            end
         end
         S_RDEC: begin
            if (stat.stopped) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_NOT_STARTED;
               state_in       = S_IDLE;
            end else if (stat.ro_zero) begin
               state_in = S_RLAG;
            end else begin
               state_in = S_RMEM;
            end
         end
         S_RLAG: begin
            cmd.op   = OP_LAG;
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if (stat.rp_ahead) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_WAITING;
               state_in       = S_IDLE;
            end else begin
               cb_read_in = 1'b1;
               cb_new_in  = 1'b0;
               state_in   = S_CBQ;
            end
         end
         S_RMEM: begin
            cmd.op   = OP_RMEM;
            state_in = S_RDAT;
         end
         S_RDAT: begin
            cmd.op         = OP_RDAT;
            cmd.rsp_fire   = 1'b1;
            cmd.rsp_status = ST_BYTE_OUT;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         cb_read_ff  <= 1'b0;
         cb_new_ff   <= 1'b0;
         clr_fire_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cb_read_ff  <= cb_read_in;
         cb_new_ff   <= cb_new_in;
         clr_fire_ff <= clr_fire_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

/* sv/ajb_dp.sv */
// ----------------------------------------------------------------------------
// Audio jitter buffer datapath
// Session and pointer registers, audio store, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ajb_dp #(
   parameter int STORE_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ajb_pkg::req_item_type req_item,
   input  ajb_pkg::dp_cmd_type   cmd,
   input  logic [16:0]           buffer_bytes,
   output ajb_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output ajb_pkg::rsp_item_type rsp_item
);
   import ajb_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);

   logic [7:0] audio_store [STORE_BYTES];

   req_item_type req_ff, req_in;
   logic [63:0]  session_now_ff, session_now_in;
   logic         session_ok_ff, session_ok_in;
   logic [16:0]  packet_size_ff, packet_size_in;
   logic [16:0]  cell_count_ff, cell_count_in;
   logic [63:0]  start_byte_ff, start_byte_in;
   logic [63:0]  highest_byte_ff, highest_byte_in;
   logic [63:0]  read_position_ff, read_position_in;
   logic [16:0]  read_offset_ff, read_offset_in;
   logic         playing_ff, playing_in;
   logic [16:0]  write_base_ff, write_base_in;
   logic [16:0]  write_offset_ff, write_offset_in;
   logic         payload_accept_ff, payload_accept_in;
   logic [33:0]  span_ff, span_in;
   logic [63:0]  hms_ff, hms_in;
   logic         f_lt_ff, f_lt_in;
   logic         f_gt_ff, f_gt_in;
   logic         f_bad_ff, f_bad_in;
   logic         f_inval_ff, f_inval_in;
   logic         f_stopped_ff, f_stopped_in;
   logic         f_le_start_ff, f_le_start_in;
   logic         f_ge_span_ff, f_ge_span_in;
   logic [16:0]  cb_ff, cb_in;
   logic [16:0]  read_base_ff, read_base_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic [7:0]   rdata_ff;

   logic [16:0]  eff;
   logic         bad_len;
   logic [18:0]  eff3;
   logic [63:0]  diff;
   logic [16:0]  wr_idx;
   logic [16:0]  rd_idx;
   logic         pay_ok;
   logic [16:0]  ro_next;
   logic         cell_end;
   logic         inval;
   logic         clr_last;
   logic         mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]   mem_wdata;

   logic         div_start;
   logic [63:0]  div_dividend;
   logic [16:0]  div_divisor;
   logic         div_busy;
   logic [63:0]  div_quo;
   logic [16:0]  div_rem;

   // clip the configured size to the store and to at least one byte
   always_comb begin
      if (21'(buffer_bytes) > 21'(STORE_BYTES)) begin
         eff = 17'(STORE_BYTES);
      end else if (buffer_bytes == 17'd0) begin
         eff = 17'd1;
      end else begin
         eff = buffer_bytes;
      end
   end

   assign bad_len  = (req_ff.payload_len == 16'd0) || ({1'b0, req_ff.payload_len} > eff);
   assign eff3     = {2'b00, eff} + {1'b0, eff, 1'b0};
   assign diff     = highest_byte_ff - start_byte_ff;
   assign wr_idx   = write_base_ff + write_offset_ff;
   assign rd_idx   = read_base_ff + read_offset_ff;
   assign pay_ok   = payload_accept_ff && (write_offset_ff < packet_size_ff);
   assign ro_next  = read_offset_ff + 17'd1;
   assign cell_end = ro_next >= packet_size_ff;
   assign inval    = !session_ok_ff || (packet_size_ff == 17'd0) || (cell_count_ff == 17'd0);
   assign clr_last = clr_cnt_ff == AW'(STORE_BYTES - 1);

   assign div_start = (cmd.op == OP_DIV_CC) || (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_R);

   always_comb begin
      case (cmd.op)
         OP_DIV_CC: begin
            div_dividend = 64'(eff);
            div_divisor  = {1'b0, req_ff.payload_len};
         end
         OP_DIV_Q: begin
            div_dividend = cmd.src_rp ? read_position_ff : req_ff.first_byte;
            div_divisor  = packet_size_ff;
         end
         default: begin
            div_dividend = div_quo;
            div_divisor  = cell_count_ff;
         end
      endcase
   end

   ajb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      req_in            = req_ff;
      session_now_in    = session_now_ff;
      session_ok_in     = session_ok_ff;
      packet_size_in    = packet_size_ff;
      cell_count_in     = cell_count_ff;
      start_byte_in     = start_byte_ff;
      highest_byte_in   = highest_byte_ff;
      read_position_in  = read_position_ff;
      read_offset_in    = read_offset_ff;
      playing_in        = playing_ff;
      write_base_in     = write_base_ff;
      write_offset_in   = write_offset_ff;
      payload_accept_in = payload_accept_ff;
      span_in           = span_ff;
      hms_in            = hms_ff;
      f_lt_in           = f_lt_ff;
      f_gt_in           = f_gt_ff;
      f_bad_in          = f_bad_ff;
      f_inval_in        = f_inval_ff;
      f_stopped_in      = f_stopped_ff;
      f_le_start_in     = f_le_start_ff;
      f_ge_span_in      = f_ge_span_ff;
      cb_in             = cb_ff;
      read_base_in      = read_base_ff;
      clr_cnt_in        = clr_cnt_ff;
      case (cmd.op)
         OP_LATCH: begin
            req_in = req_item;
         end
         OP_EVAL: begin
            f_lt_in       = req_ff.session_number < session_now_ff;
            f_gt_in       = req_ff.session_number > session_now_ff;
            f_bad_in      = bad_len;
            f_inval_in    = inval;
            f_stopped_in  = !playing_ff || inval;
            f_le_start_in = req_ff.first_byte <= start_byte_ff;
            f_ge_span_in  = highest_byte_ff >= 64'(span_ff);
            hms_in        = highest_byte_ff - 64'(span_ff);
         end
         OP_HDR_NEW: begin
            session_now_in    = req_ff.session_number;
            playing_in        = 1'b0;
            payload_accept_in = 1'b0;
            read_offset_in    = '0;
            write_offset_in   = '0;
            session_ok_in     = !f_bad_ff;
            if (!f_bad_ff) begin
               packet_size_in   = {1'b0, req_ff.payload_len};
               start_byte_in    = req_ff.first_byte;
               read_position_in = req_ff.first_byte;
               highest_byte_in  = req_ff.first_byte;
            end
         end
         OP_HDR_SAME: begin
            payload_accept_in = 1'b0;
         end
         OP_SET_CC: begin
            cell_count_in = div_quo[16:0];
         end
         OP_SET_SPAN: begin
            span_in = cell_count_ff * packet_size_ff;
         end
         OP_MUL: begin
            cb_in = 17'(div_rem * packet_size_ff);
         end
         OP_SET_WB: begin
            write_base_in     = cb_ff;
            write_offset_in   = '0;
            payload_accept_in = 1'b1;
            if (req_ff.first_byte > highest_byte_ff) begin
               highest_byte_in = req_ff.first_byte;
            end
         end
         OP_SET_RB: begin
            read_base_in = cb_ff;
         end
         OP_CHK: begin
            if (diff >= 64'(eff3[18:2])) begin
               playing_in = 1'b1;
            end
         end
         OP_PAY: begin
            if (pay_ok) begin
               write_offset_in = write_offset_ff + 17'd1;
            end
            if (req_ff.byte_last) begin
               payload_accept_in = 1'b0;
            end
         end
         OP_LAG: begin
            // skip ahead when the reader lags the buffer
            if (f_ge_span_ff && (read_position_ff < hms_ff)) begin
               read_position_in = hms_ff;
            end
         end
         OP_RDAT: begin
            if (cell_end) begin
               read_offset_in   = '0;
               read_position_in = read_position_ff + 64'(packet_size_ff);
            end else begin
               read_offset_in = ro_next;
            end
         end
         OP_CLR: begin
            clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_fire;
      rsp_in       = rsp_ff;
      if (cmd.rsp_fire) begin
         rsp_in.status    = cmd.rsp_status;
         rsp_in.out_byte  = (cmd.op == OP_RDAT) ? rdata_ff : 8'd0;
         rsp_in.cell_last = (cmd.op == OP_RDAT) && cell_end;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = 8'd0;
      case (cmd.op)
         OP_CLR: begin
            mem_we = 1'b1;
         end
         OP_PAY: begin
            mem_we    = pay_ok;
            mem_waddr = AW'(wr_idx);
            mem_wdata = req_ff.data_byte;
         end
         OP_RDAT: begin
            // zero the byte once it has been played
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_idx);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         audio_store[mem_waddr] <= mem_wdata;
      end
      if (cmd.op == OP_RMEM) begin
         rdata_ff <= audio_store[AW'(rd_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_now_ff    <= '0;
         session_ok_ff     <= 1'b0;
         packet_size_ff    <= '0;
         cell_count_ff     <= '0;
         start_byte_ff     <= '0;
         highest_byte_ff   <= '0;
         read_position_ff  <= '0;
         read_offset_ff    <= '0;
         playing_ff        <= 1'b0;
         write_base_ff     <= '0;
         write_offset_ff   <= '0;
         payload_accept_ff <= 1'b0;
         span_ff           <= '0;
         read_base_ff      <= '0;
         clr_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         session_now_ff    <= session_now_in;
         session_ok_ff     <= session_ok_in;
         packet_size_ff    <= packet_size_in;
         cell_count_ff     <= cell_count_in;
         start_byte_ff     <= start_byte_in;
         highest_byte_ff   <= highest_byte_in;
         read_position_ff  <= read_position_in;
         read_offset_ff    <= read_offset_in;
         playing_ff        <= playing_in;
         write_base_ff     <= write_base_in;
         write_offset_ff   <= write_offset_in;
         payload_accept_ff <= payload_accept_in;
         span_ff           <= span_in;
         read_base_ff      <= read_base_in;
         clr_cnt_ff        <= clr_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      req_ff        <= req_in;
      hms_ff        <= hms_in;
      f_lt_ff       <= f_lt_in;
      f_gt_ff       <= f_gt_in;
      f_bad_ff      <= f_bad_in;
      f_inval_ff    <= f_inval_in;
      f_stopped_ff  <= f_stopped_in;
      f_le_start_ff <= f_le_start_in;
      f_ge_span_ff  <= f_ge_span_in;
      cb_ff         <= cb_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      stat             = '0;
      stat.req_kind    = req_ff.req_type;
      stat.sess_lt     = f_lt_ff;
      stat.sess_gt     = f_gt_ff;
      stat.bad_len     = f_bad_ff;
      stat.inval       = f_inval_ff;
      stat.fb_le_start = f_le_start_ff;
      stat.fb_in_lag   = f_ge_span_ff && (req_ff.first_byte <= hms_ff);
      stat.stopped     = f_stopped_ff;
      stat.ro_zero     = read_offset_ff == 17'd0;
      stat.rp_ahead    = read_position_ff > highest_byte_ff;
      stat.pay_ok      = pay_ok;
      stat.div_busy    = div_busy;
      stat.clr_last    = clr_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_read_offset : assert property (@(posedge clock) disable iff (reset)
      (packet_size_ff != 17'd0) |-> (read_offset_ff < packet_size_ff))
      else $error("read offset past packet size");

   a_write_offset : assert property (@(posedge clock) disable iff (reset)
      write_offset_ff <= packet_size_ff)
      else $error("write offset past packet size");

   a_div_start : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

endmodule
